// ----- rtl/ecpsm_pkg.sv -----
`timescale 1ns / 1ps
package ecpsm_pkg;

   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_FIELD_MODULUS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CURVE_COEFF_A = 2'd1;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

endpackage

// ----- rtl/ecpsm_alu.sv -----
`timescale 1ns / 1ps
module ecpsm_alu #(
   parameter int FIELD_BITS = 30
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ecpsm_pkg::alu_ctl_type  ctl,
   input  logic [FIELD_BITS-1:0]   opa,
   input  logic [FIELD_BITS-1:0]   opb,
   input  logic [FIELD_BITS-1:0]   modulus,
   output logic                    done,
   output logic [FIELD_BITS-1:0]   res,
   output logic [FIELD_BITS-1:0]   quo
);
   import ecpsm_pkg::*;

   localparam int CW = $clog2(FIELD_BITS + 1);

   logic                  busy_ff, busy_in;
   alu_op_type            op_ff, op_in;
   logic [FIELD_BITS-1:0] a_ff, a_in;
   logic [FIELD_BITS-1:0] b_ff, b_in;
   logic [FIELD_BITS-1:0] acc_ff, acc_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  phase_ff, phase_in;
   logic                  done_ff, done_in;
   logic [FIELD_BITS-1:0] addsel;
   logic [FIELD_BITS:0]   trial;
   logic                  qbit;

   // x + y mod p, both operands below p
   function automatic logic [FIELD_BITS-1:0] add_mod(input logic [FIELD_BITS-1:0] x,
                                                     input logic [FIELD_BITS-1:0] y,
                                                     input logic [FIELD_BITS-1:0] p);
      logic [FIELD_BITS:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, p}) begin
         s = s - {1'b0, p};
      end
      return s[FIELD_BITS-1:0];
   endfunction

   function automatic logic [FIELD_BITS-1:0] sub_mod(input logic [FIELD_BITS-1:0] x,
                                                     input logic [FIELD_BITS-1:0] y,
                                                     input logic [FIELD_BITS-1:0] p);
      logic [FIELD_BITS-1:0] d;
      d = x - y;
      if (x < y) begin
         d = d + p;
      end
      return d;
   endfunction

   always_comb begin
      busy_in  = busy_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      addsel   = phase_ff ? a_ff : acc_ff;
      trial    = {acc_ff, a_ff[FIELD_BITS-1]};
      qbit     = 1'b0;
      if (!busy_ff) begin
         if (ctl.start) begin
            op_in = ctl.op;
            a_in  = opa;
            b_in  = opb;
            unique case (ctl.op)
               ALU_ADD: begin
                  acc_in  = add_mod(opa, opb, modulus);
                  done_in = 1'b1;
               end
               ALU_SUB: begin
                  acc_in  = sub_mod(opa, opb, modulus);
                  done_in = 1'b1;
               end
               default: begin
                  acc_in   = '0;
                  cnt_in   = CW'(FIELD_BITS);
                  phase_in = 1'b0;
                  busy_in  = 1'b1;
               end
            endcase
         end
      end else begin
         if (op_ff == ALU_MUL) begin
            // double, then add the multiplicand when the multiplier bit is set
            acc_in = add_mod(acc_ff, addsel, modulus);
            if (!phase_ff && b_ff[FIELD_BITS-1]) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               b_in     = {b_ff[FIELD_BITS-2:0], 1'b0};
               cnt_in   = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         end else begin
            // restoring division, one quotient bit per cycle
            if (trial >= {1'b0, b_ff}) begin
               trial = trial - {1'b0, b_ff};
               qbit  = 1'b1;
            end
            acc_in = trial[FIELD_BITS-1:0];
            a_in   = {a_ff[FIELD_BITS-2:0], qbit};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
   end

   assign done = done_ff;
   assign res  = acc_ff;
   assign quo  = a_ff;

`ifndef SYNTHESIS
   a_mul_reduced: assert property (@(posedge clock) disable iff (reset)
      (done_ff && op_ff == ALU_MUL) |-> (acc_ff < modulus))
      else $error("modular product not reduced");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctl.start)
      else $error("operation issued while unit busy");
`endif

endmodule

// ----- rtl/ec_point_scalar_multiply_core.sv -----
`timescale 1ns / 1ps
// Elliptic-curve scalar multiply k*P over GF(p), affine left-to-right double-and-add, with
// (0,0) standing for the point at infinity (also flagged on rsp_tuser). All field work runs
// on one shared modular unit that adds, subtracts, multiplies and divides. An item starts
// with three divides that reduce the inputs, then per scalar bit one doubling and (for a set
// bit) one addition; each of those is 9 to 12 operations plus an extended-Euclid inversion,
// so the inversion loop dominates and the time per item is data dependent. req_tready is
// high only while idle.
module ec_point_scalar_multiply_core #(
   parameter int FIELD_BITS = 30
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // scalar, base_x, base_y, zero pad
   input  logic [((3*FIELD_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // result_x, result_y, zero pad
   output logic [((2*FIELD_BITS+7)/8)*8-1:0]    rsp_tdata,
   // at_infinity
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic [ecpsm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [FIELD_BITS-1:0]                csr_wdata
);
   import ecpsm_pkg::*;

   localparam int OUT_W = ((2*FIELD_BITS+7)/8)*8;
   localparam int IW    = $clog2(FIELD_BITS);
   localparam logic [FIELD_BITS-1:0] P_RESET = FIELD_BITS'(64'd1000003);

   typedef enum logic [24:0] {
      S_IDLE = 25'd1 << 0,  S_RBX  = 25'd1 << 1,  S_RBY  = 25'd1 << 2,
      S_RA   = 25'd1 << 3,  S_PCHK = 25'd1 << 4,  S_XX   = 25'd1 << 5,
      S_N1   = 25'd1 << 6,  S_N2   = 25'd1 << 7,  S_N3   = 25'd1 << 8,
      S_DEND = 25'd1 << 9,  S_NSUB = 25'd1 << 10, S_DSUB = 25'd1 << 11,
      S_ICHK = 25'd1 << 12, S_DIV  = 25'd1 << 13, S_QMUL = 25'd1 << 14,
      S_TSUB = 25'd1 << 15, S_LAM  = 25'd1 << 16, S_LL   = 25'd1 << 17,
      S_X3A  = 25'd1 << 18, S_X3B  = 25'd1 << 19, S_U    = 25'd1 << 20,
      S_LU   = 25'd1 << 21, S_Y3   = 25'd1 << 22, S_NEXT = 25'd1 << 23,
      S_OUT  = 25'd1 << 24
   } state_type;

   state_type             state_ff, state_in;
   logic                  issued_ff, issued_in;
   logic [FIELD_BITS-1:0] p_ff, p_in, acfg_ff, acfg_in;
   logic [FIELD_BITS-1:0] k_ff, k_in, bx_ff, bx_in, by_ff, by_in, ared_ff, ared_in;
   logic [FIELD_BITS-1:0] rx_ff, rx_in, ry_ff, ry_in, num_ff, num_in, m_ff, m_in;
   logic [FIELD_BITS-1:0] lam_ff, lam_in, x3_ff, x3_in;
   logic [FIELD_BITS-1:0] r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [FIELD_BITS-1:0] q_ff, q_in, nr_ff, nr_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  addb_ff, addb_in;
   logic                  rsp_valid_ff, rsp_valid_in, rsp_inf_ff, rsp_inf_in;
   logic [FIELD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   alu_ctl_type           alu_ctl;
   logic [FIELD_BITS-1:0] alu_a, alu_b, alu_res, alu_quo;
   logic                  alu_done;
   logic [FIELD_BITS-1:0] qx, qy;
   logic                  op_state, capture;

   ecpsm_alu #(.FIELD_BITS(FIELD_BITS)) u_alu (
      .clock   (clock),
      .reset   (reset),
      .ctl     (alu_ctl),
      .opa     (alu_a),
      .opb     (alu_b),
      .modulus (p_ff),
      .done    (alu_done),
      .res     (alu_res),
      .quo     (alu_quo)
   );

   assign qx = addb_ff ? bx_ff : rx_ff;
   assign qy = addb_ff ? by_ff : ry_ff;

   // operand select for the shared unit
   always_comb begin
      alu_ctl.op = ALU_ADD;
      alu_a      = '0;
      alu_b      = '0;
      op_state   = 1'b1;
      unique case (state_ff)
         S_RBX:  begin alu_ctl.op = ALU_DIV; alu_a = bx_ff;  alu_b = p_ff;   end
         S_RBY:  begin alu_ctl.op = ALU_DIV; alu_a = by_ff;  alu_b = p_ff;   end
         S_RA:   begin alu_ctl.op = ALU_DIV; alu_a = acfg_ff; alu_b = p_ff;  end
         S_XX:   begin alu_ctl.op = ALU_MUL; alu_a = rx_ff;  alu_b = rx_ff;  end
         S_N1:   begin alu_ctl.op = ALU_ADD; alu_a = m_ff;   alu_b = m_ff;   end
         S_N2:   begin alu_ctl.op = ALU_ADD; alu_a = num_ff; alu_b = m_ff;   end
         S_N3:   begin alu_ctl.op = ALU_ADD; alu_a = num_ff; alu_b = ared_ff; end
         S_DEND: begin alu_ctl.op = ALU_ADD; alu_a = ry_ff;  alu_b = ry_ff;  end
         S_NSUB: begin alu_ctl.op = ALU_SUB; alu_a = qy;     alu_b = ry_ff;  end
         S_DSUB: begin alu_ctl.op = ALU_SUB; alu_a = qx;     alu_b = rx_ff;  end
         S_DIV:  begin alu_ctl.op = ALU_DIV; alu_a = r0_ff;  alu_b = r1_ff;  end
         S_QMUL: begin alu_ctl.op = ALU_MUL; alu_a = q_ff;   alu_b = t1_ff;  end
         S_TSUB: begin alu_ctl.op = ALU_SUB; alu_a = t0_ff;  alu_b = m_ff;   end
         S_LAM:  begin alu_ctl.op = ALU_MUL; alu_a = num_ff; alu_b = t0_ff;  end
         S_LL:   begin alu_ctl.op = ALU_MUL; alu_a = lam_ff; alu_b = lam_ff; end
         S_X3A:  begin alu_ctl.op = ALU_SUB; alu_a = x3_ff;  alu_b = rx_ff;  end
         S_X3B:  begin alu_ctl.op = ALU_SUB; alu_a = x3_ff;  alu_b = qx;     end
         S_U:    begin alu_ctl.op = ALU_SUB; alu_a = rx_ff;  alu_b = x3_ff;  end
         S_LU:   begin alu_ctl.op = ALU_MUL; alu_a = lam_ff; alu_b = m_ff;   end
         S_Y3:   begin alu_ctl.op = ALU_SUB; alu_a = m_ff;   alu_b = ry_ff;  end
         default: op_state = 1'b0;
      endcase
      alu_ctl.start = op_state && !issued_ff;
      capture       = op_state && issued_ff && alu_done;
   end

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      p_in         = p_ff;
      acfg_in      = acfg_ff;
      k_in         = k_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      ared_in      = ared_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      num_in       = num_ff;
      m_in         = m_ff;
      lam_in       = lam_ff;
      x3_in        = x3_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      q_in         = q_ff;
      nr_in        = nr_ff;
      idx_in       = idx_ff;
      addb_in      = addb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_inf_in   = rsp_inf_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_FIELD_MODULUS: p_in    = csr_wdata;
            REG_CURVE_COEFF_A: acfg_in = csr_wdata;
            default: ;
         endcase
      end

      if (alu_ctl.start) begin
         issued_in = 1'b1;
      end
      if (capture) begin
         issued_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               k_in    = req_tdata[FIELD_BITS-1:0];
               bx_in   = req_tdata[2*FIELD_BITS-1:FIELD_BITS];
               by_in   = req_tdata[3*FIELD_BITS-1:2*FIELD_BITS];
               rx_in   = '0;
               ry_in   = '0;
               idx_in  = IW'(FIELD_BITS - 1);
               addb_in = 1'b0;
               // no field below modulus 2: answer infinity
               state_in = (p_ff < FIELD_BITS'(2)) ? S_OUT : S_RBX;
            end
         end
         S_RBX: if (capture) begin bx_in = alu_res; state_in = S_RBY; end
         S_RBY: if (capture) begin by_in = alu_res; state_in = S_RA; end
         S_RA:  if (capture) begin ared_in = alu_res; state_in = S_PCHK; end
         S_PCHK: begin
            if (qx == '0 && qy == '0) begin
               state_in = S_NEXT;
            end else if (rx_ff == '0 && ry_ff == '0) begin
               rx_in    = qx;
               ry_in    = qy;
               state_in = S_NEXT;
            end else if (rx_ff == qx && ry_ff == qy) begin
               state_in = S_XX;
            end else begin
               state_in = S_NSUB;
            end
         end
         S_XX:   if (capture) begin m_in = alu_res; state_in = S_N1; end
         S_N1:   if (capture) begin num_in = alu_res; state_in = S_N2; end
         S_N2:   if (capture) begin num_in = alu_res; state_in = S_N3; end
         S_N3:   if (capture) begin num_in = alu_res; state_in = S_DEND; end
         S_NSUB: if (capture) begin num_in = alu_res; state_in = S_DSUB; end
         S_DEND, S_DSUB: begin
            if (capture) begin
               if (alu_res == '0) begin
                  rx_in    = '0;
                  ry_in    = '0;
                  state_in = S_NEXT;
               end else begin
                  r0_in    = p_ff;
                  r1_in    = alu_res;
                  t0_in    = '0;
                  t1_in    = FIELD_BITS'(1);
                  state_in = S_ICHK;
               end
            end
         end
         S_ICHK: state_in = (r1_ff == '0) ? S_LAM : S_DIV;
         S_DIV: begin
            if (capture) begin
               // quotient never exceeds p; reduce it
               q_in     = (alu_quo == p_ff) ? '0 : alu_quo;
               nr_in    = alu_res;
               state_in = S_QMUL;
            end
         end
         S_QMUL: if (capture) begin m_in = alu_res; state_in = S_TSUB; end
         S_TSUB: begin
            if (capture) begin
               r0_in    = r1_ff;
               r1_in    = nr_ff;
               t0_in    = t1_ff;
               t1_in    = alu_res;
               state_in = S_ICHK;
            end
         end
         S_LAM:  if (capture) begin lam_in = alu_res; state_in = S_LL; end
         S_LL:   if (capture) begin x3_in = alu_res; state_in = S_X3A; end
         S_X3A:  if (capture) begin x3_in = alu_res; state_in = S_X3B; end
         S_X3B:  if (capture) begin x3_in = alu_res; state_in = S_U; end
         S_U:    if (capture) begin m_in = alu_res; state_in = S_LU; end
         S_LU:   if (capture) begin m_in = alu_res; state_in = S_Y3; end
         S_Y3: begin
            if (capture) begin
               rx_in    = x3_ff;
               ry_in    = alu_res;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (!addb_ff && k_ff[idx_ff]) begin
               addb_in  = 1'b1;
               state_in = S_PCHK;
            end else if (idx_ff == '0) begin
               state_in = S_OUT;
            end else begin
               addb_in  = 1'b0;
               idx_in   = idx_ff - IW'(1);
               state_in = S_PCHK;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = rx_ff;
               rsp_y_in     = ry_ff;
               rsp_inf_in   = (rx_ff == '0) && (ry_ff == '0);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         p_ff         <= P_RESET;
         acfg_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         p_ff         <= p_in;
         acfg_ff      <= acfg_in;
      end
      k_ff     <= k_in;
      bx_ff    <= bx_in;
      by_ff    <= by_in;
      ared_ff  <= ared_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      num_ff   <= num_in;
      m_ff     <= m_in;
      lam_ff   <= lam_in;
      x3_ff    <= x3_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      q_ff     <= q_in;
      nr_ff    <= nr_in;
      idx_ff   <= idx_in;
      addb_ff  <= addb_in;
      rsp_inf_ff <= rsp_inf_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_inf_ff;

`ifndef SYNTHESIS
   a_inf_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_inf_ff == (rsp_x_ff == '0 && rsp_y_ff == '0)))
      else $error("infinity flag does not match coordinates");
   a_point_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEXT) |-> (rx_ff < p_ff && ry_ff < p_ff))
      else $error("running point not reduced");
   a_euclid_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ICHK) |-> (r1_ff < r0_ff))
      else $error("Euclid remainder did not shrink");
`endif

endmodule
